// ----- hdl/hjc_pkg.sv -----
// ----------------------------------------------------------------------------
// hjc_pkg
// Shared types and constants of the two-set Hangul jamo composer.
// ----------------------------------------------------------------------------
package hjc_pkg;

    localparam logic [15:0] KEY_BS     = 16'h0008;
    localparam logic [15:0] CONS_FIRST = 16'h3131;
    localparam logic [15:0] CONS_LAST  = 16'h314E;
    localparam logic [15:0] VOW_LAST   = 16'h3163;
    localparam logic [15:0] JAMO_BASE  = 16'h3130;
    localparam logic [15:0] SYL_BASE   = 16'hAC00;
    localparam logic [15:0] BAD_CODE   = 16'hFFFF;

    // jamo slot: code minus 0x3130, 0 means empty
    typedef logic [5:0] jamo_t;

    typedef struct packed {
        jamo_t ini;
        jamo_t m0;
        jamo_t m1;
        jamo_t f0;
        jamo_t f1;
    } jstate_t;

    typedef struct packed {
        logic [15:0] code;
        logic        prog;
        logic        bad;
        logic        last;
    } result_t;

    typedef struct packed {
        result_t first;
        result_t second;
        logic    first_v;
        logic    second_v;
    } res_pair_t;

endpackage

// ----- hdl/hjc_compose.sv -----
// ----------------------------------------------------------------------------
// hjc_compose
// Next-state and result logic of the composition automaton for one key.
// ----------------------------------------------------------------------------
module hjc_compose (
    input  logic [15:0]        key,
    input  hjc_pkg::jstate_t   st,
    output hjc_pkg::jstate_t   st_nx,
    output hjc_pkg::res_pair_t res
);

    typedef enum logic [1:0] {
        KC_BS,
        KC_PASS,
        KC_CONS,
        KC_VOW
    } kclass_t;

    function automatic hjc_pkg::jamo_t pair_of(hjc_pkg::jamo_t a, hjc_pkg::jamo_t b);
        hjc_pkg::jamo_t p;
        p = '0;
        case (a)
            6'h01: if (b == 6'h15) p = 6'h03;
            6'h04: begin
                if (b == 6'h18) p = 6'h05;
                else if (b == 6'h1E) p = 6'h06;
            end
            6'h09: begin
                case (b)
                    6'h01:   p = 6'h0A;
                    6'h11:   p = 6'h0B;
                    6'h12:   p = 6'h0C;
                    6'h15:   p = 6'h0D;
                    6'h1C:   p = 6'h0E;
                    6'h1D:   p = 6'h0F;
                    6'h1E:   p = 6'h10;
                    default: p = '0;
                endcase
            end
            6'h12: if (b == 6'h15) p = 6'h14;
            6'h27: begin
                if (b == 6'h1F) p = 6'h28;
                else if (b == 6'h20) p = 6'h29;
                else if (b == 6'h33) p = 6'h2A;
            end
            6'h2C: begin
                if (b == 6'h23) p = 6'h2D;
                else if (b == 6'h24) p = 6'h2E;
                else if (b == 6'h33) p = 6'h2F;
            end
            6'h31: if (b == 6'h33) p = 6'h32;
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic logic can_join(hjc_pkg::jamo_t a, hjc_pkg::jamo_t b);
        return (a == '0) || (b == '0) || (pair_of(a, b) != '0);
    endfunction

    function automatic hjc_pkg::jamo_t join_of(hjc_pkg::jamo_t a, hjc_pkg::jamo_t b);
        hjc_pkg::jamo_t p;
        p = pair_of(a, b);
        if (a == '0) return b;
        if (b == '0) return a;
        return (p != '0) ? p : a;
    endfunction

    // {valid, initial index}
    function automatic logic [5:0] init_idx(hjc_pkg::jamo_t s);
        logic [5:0] r;
        r = '0;
        case (s)
            6'h01: r = {1'b1, 5'd0};
            6'h02: r = {1'b1, 5'd1};
            6'h04: r = {1'b1, 5'd2};
            6'h07: r = {1'b1, 5'd3};
            6'h08: r = {1'b1, 5'd4};
            6'h09: r = {1'b1, 5'd5};
            6'h11: r = {1'b1, 5'd6};
            6'h12: r = {1'b1, 5'd7};
            6'h13: r = {1'b1, 5'd8};
            default: begin
                if (s >= 6'h15 && s <= 6'h1E) r = {1'b1, 5'(s - 6'd12)};
            end
        endcase
        return r;
    endfunction

    // {valid, final index + 1}
    function automatic logic [5:0] fin_idx(hjc_pkg::jamo_t s);
        logic [5:0] r;
        r = '0;
        if (s >= 6'h01 && s <= 6'h07) r = {1'b1, s[4:0]};
        else if (s >= 6'h09 && s <= 6'h12) r = {1'b1, 5'(s - 6'd1)};
        else if (s >= 6'h14 && s <= 6'h18) r = {1'b1, 5'(s - 6'd2)};
        else if (s >= 6'h1A && s <= 6'h1E) r = {1'b1, 5'(s - 6'd3)};
        return r;
    endfunction

    // {bad, code}
    function automatic logic [16:0] syl_of(hjc_pkg::jstate_t s);
        hjc_pkg::jamo_t med;
        hjc_pkg::jamo_t fin;
        logic [5:0]     iv;
        logic [5:0]     fv;
        logic           bad;
        logic [15:0]    code;
        med  = join_of(s.m0, s.m1);
        fin  = join_of(s.f0, s.f1);
        iv   = init_idx(s.ini);
        fv   = fin_idx(fin);
        bad  = 1'b0;
        code = '0;
        if (s.ini == '0) begin
            code = (med == '0) ? 16'h0000 : hjc_pkg::JAMO_BASE + 16'(med);
        end else if (med == '0) begin
            code = hjc_pkg::JAMO_BASE + 16'(s.ini);
        end else if (med < 6'h1F || med > 6'h33 || !iv[5] ||
                     (fin != '0 && !fv[5])) begin
            bad  = 1'b1;
            code = hjc_pkg::BAD_CODE;
        end else begin
            code = hjc_pkg::SYL_BASE + 16'(iv[4:0]) * 16'd588
                 + 16'(med - 6'h1F) * 16'd28 + 16'(fv[4:0]);
        end
        return {bad, code};
    endfunction

    kclass_t          kc;
    logic [15:0]      key_off;
    hjc_pkg::jamo_t   kslot;
    logic             no_final;
    logic             do_flush;
    hjc_pkg::jstate_t st_fl;
    logic [16:0]      syl_fl;
    logic [16:0]      syl_nx;
    hjc_pkg::result_t r0;
    hjc_pkg::result_t r1;
    logic             r0_v;
    logic             r1_v;

    assign key_off  = key - hjc_pkg::JAMO_BASE;
    assign kslot    = key_off[5:0];
    assign no_final = (kslot == 6'h08) || (kslot == 6'h13) || (kslot == 6'h19);

    always_comb begin
        if (key == hjc_pkg::KEY_BS) kc = KC_BS;
        else if (key < hjc_pkg::CONS_FIRST || key > hjc_pkg::VOW_LAST) kc = KC_PASS;
        else if (key <= hjc_pkg::CONS_LAST) kc = KC_CONS;
        else kc = KC_VOW;
    end

    always_comb begin
        st_fl    = st;
        st_nx    = st;
        do_flush = 1'b0;
        unique case (kc)
            KC_BS: begin
                if (st.f1 != '0) st_nx.f1 = '0;
                else if (st.f0 != '0) st_nx.f0 = '0;
                else if (st.m1 != '0) st_nx.m1 = '0;
                else if (st.m0 != '0) st_nx.m0 = '0;
                else st_nx.ini = '0;
            end
            KC_PASS: begin
                do_flush = 1'b1;
                st_nx    = '0;
            end
            KC_CONS: begin
                if (st.ini == '0 || st.m0 == '0 || no_final || st.f1 != '0 ||
                    !can_join(st.f0, kslot)) begin
                    do_flush  = 1'b1;
                    st_nx     = '0;
                    st_nx.ini = kslot;
                end else if (st.f0 == '0) begin
                    st_nx.f0 = kslot;
                end else begin
                    st_nx.f1 = kslot;
                end
            end
            KC_VOW: begin
                if (st.f0 != '0) begin
                    do_flush = 1'b1;
                    st_nx    = '0;
                    st_nx.m0 = kslot;
                    if (st.f1 != '0) begin
                        st_fl.f1  = '0;
                        st_nx.ini = st.f1;
                    end else begin
                        st_fl.f0  = '0;
                        st_nx.ini = st.f0;
                    end
                end else if (st.m1 != '0 || !can_join(st.m0, kslot)) begin
                    do_flush = 1'b1;
                    st_nx    = '0;
                    st_nx.m0 = kslot;
                end else if (st.m0 == '0) begin
                    st_nx.m0 = kslot;
                end else begin
                    st_nx.m1 = kslot;
                end
            end
            default: st_nx = st;
        endcase
    end

    assign syl_fl = syl_of(st_fl);
    assign syl_nx = syl_of(st_nx);

    always_comb begin
        r0      = '0;
        r0.code = syl_fl[15:0];
        r0.bad  = syl_fl[16];
        r0_v    = do_flush && (syl_fl[15:0] != '0);
        r1      = '0;
        unique case (kc)
            KC_BS:   r1.code = (st == '0) ? key : 16'h0000;
            KC_PASS: r1.code = key;
            KC_CONS, KC_VOW: begin
                r1.code = syl_nx[15:0];
                r1.bad  = syl_nx[16];
                r1.prog = 1'b1;
            end
            default: r1 = '0;
        endcase
        r1_v = (r1.code != '0);
        r0.last = !r1_v;
        r1.last = 1'b1;
    end

    always_comb begin
        res = '0;
        if (r0_v) begin
            res.first    = r0;
            res.first_v  = 1'b1;
            res.second   = r1;
            res.second_v = r1_v;
        end else begin
            res.first    = r1;
            res.first_v  = r1_v;
        end
    end

endmodule

// ----- hdl/hjc_out_buf.sv -----
// ----------------------------------------------------------------------------
// hjc_out_buf
// Two-entry result register; drains the results of one key in order.
// ----------------------------------------------------------------------------
module hjc_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ld_valid,
    output logic                ld_ready,
    input  hjc_pkg::res_pair_t  pair,
    output logic                out_valid,
    input  logic                out_ready,
    output hjc_pkg::result_t    out_item
);

    hjc_pkg::result_t e0_reg, e0_next;
    hjc_pkg::result_t e1_reg, e1_next;
    logic             v0_reg, v0_next;
    logic             v1_reg, v1_next;

    assign ld_ready  = !v0_reg || (out_ready && !v1_reg);
    assign out_valid = v0_reg;
    assign out_item  = e0_reg;

    always_comb begin
        e0_next = e0_reg;
        e1_next = e1_reg;
        v0_next = v0_reg;
        v1_next = v1_reg;
        if (ld_valid && ld_ready) begin
            e0_next = pair.first;
            v0_next = pair.first_v;
            e1_next = pair.second;
            v1_next = pair.second_v;
        end else if (v0_reg && out_ready) begin
            if (v1_reg) begin
                e0_next = e1_reg;
                v1_next = 1'b0;
            end else begin
                v0_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    a_second_needs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> v0_reg)
        else $error("second entry held without first");

    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (v0_reg && v1_reg) |-> !e0_reg.last)
        else $error("first of two entries marked last");

    a_load_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (ld_valid && ld_ready && pair.second_v) |=> (v0_reg && v1_reg))
        else $error("two-result load lost an entry");

endmodule

// ----- hdl/hangul_jamo_composer_top.sv -----
// ----------------------------------------------------------------------------
// hangul_jamo_composer_top
// Two-set Hangul composition automaton with stream input and output.
// ----------------------------------------------------------------------------
// Usage:
//   s_t* takes one 16-bit key code per item (backspace, jamo or any other
//   code unit). m_t* returns the characters the key causes: zero, one or two
//   items, the last one of a key flagged by m_tlast. m_tuser[0] marks the
//   in-progress syllable, m_tuser[1] a syllable with an invalid initial.
//   A key goes through the input register and then the result register
//   before its first result shows on m_t*. A key with at most one result is
//   taken every cycle while m_tready is high; a key with two results fills
//   both result entries, so the next key waits until the second drains. The
//   composition state updates in the cycle the key leaves the input register.
//   Reset empties the composition buffer and drops any held item.
//   A stall on m_tready holds the result register; once the input register
//   is also full, s_tready drops until room opens.
// ----------------------------------------------------------------------------
module hangul_jamo_composer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] key_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_code
    output logic [1:0]  m_tuser,   // [0] in_progress, [1] bad_initial
    output logic        m_tlast
);

    logic               in_v_reg, in_v_next;
    logic [15:0]        key_reg, key_next;
    hjc_pkg::jstate_t   st_reg, st_next;
    hjc_pkg::jstate_t   st_nx;
    hjc_pkg::res_pair_t res;
    hjc_pkg::result_t   out_item;
    logic               ld_ready;
    logic               advance;

    assign advance  = in_v_reg && ld_ready;
    assign s_tready = !in_v_reg || ld_ready;

    hjc_compose u_compose (
        .key   (key_reg),
        .st    (st_reg),
        .st_nx (st_nx),
        .res   (res)
    );

    hjc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ld_valid  (in_v_reg),
        .ld_ready  (ld_ready),
        .pair      (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = out_item.code;
    assign m_tuser = {out_item.bad, out_item.prog};
    assign m_tlast = out_item.last;

    always_comb begin
        in_v_next = in_v_reg;
        key_next  = key_reg;
        st_next   = advance ? st_nx : st_reg;
        if (s_tvalid && s_tready) begin
            in_v_next = 1'b1;
            key_next  = s_tdata;
        end else if (advance) begin
            in_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
            st_reg   <= '0;
        end else begin
            in_v_reg <= in_v_next;
            st_reg   <= st_next;
        end
        key_reg <= key_next;
    end

    a_no_empty_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != 16'h0000))
        else $error("empty item emitted");

    a_bad_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == hjc_pkg::BAD_CODE))
        else $error("bad initial flag without bad code");

    a_fill_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ((st_reg.m1 == '0) || (st_reg.m0 != '0)) &&
        ((st_reg.f1 == '0) || (st_reg.f0 != '0)) &&
        ((st_reg.f0 == '0) || ((st_reg.ini != '0) && (st_reg.m0 != '0))))
        else $error("composition buffer filled out of order");

endmodule

// ----- bench/hangul_jamo_composer_top_tb.sv -----
// ----------------------------------------------------------------------------
// hangul_jamo_composer_top_tb
// Self-checking bench for the two-set Hangul jamo composer. Key items go in
// on s_t*, and a predictor in the bench tracks the syllable under
// construction. Each character item on m_t* is checked field by field
// against the oldest predicted one. Both sides idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hangul_jamo_composer_top_tb;

    localparam logic [15:0] VOW_FIRST  = 16'h314F;
    localparam logic [15:0] KEY_SSANG_D = 16'h3138;
    localparam logic [15:0] KEY_SSANG_B = 16'h3143;
    localparam logic [15:0] KEY_SSANG_J = 16'h3149;
    // consonants that can't open a syllable / can't close one, by index from 0x3131
    localparam logic [29:0] INI_HOLES = 30'b00_0000_0000_1000_1111_1110_0011_0100;
    localparam logic [29:0] FIN_HOLES = 30'b00_0001_0000_0100_0000_0000_1000_0000;
    localparam int          RANDOM_PER_PHASE = 340;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic [15:0]      pending_keys[$];
    hjc_pkg::result_t expected_chars[$];
    hjc_pkg::result_t key_results[$];
    hjc_pkg::jstate_t comp;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int keys_accepted = 0;
    int chars_seen = 0;
    int bad_chars_seen = 0;
    int double_keys = 0;
    int mismatches = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    hjc_pkg::result_t got_char;
    hjc_pkg::result_t exp_char;

    hangul_jamo_composer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // composition predictor
    // ------------------------------------------------------------------------
    function automatic logic [15:0] jamo_code(input hjc_pkg::jamo_t s);
        return (s == '0) ? 16'h0000 : hjc_pkg::JAMO_BASE + 16'(s);
    endfunction

    function automatic hjc_pkg::jamo_t jamo_slot(input logic [15:0] c);
        return hjc_pkg::jamo_t'(c - hjc_pkg::JAMO_BASE);
    endfunction

    function automatic logic [15:0] pair_code(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] p;
        p = 16'h0000;
        case (a)
            16'h3131: if (b == 16'h3145) p = 16'h3133;
            16'h3134: begin
                if (b == 16'h3148) p = 16'h3135;
                else if (b == 16'h314E) p = 16'h3136;
            end
            16'h3139: begin
                case (b)
                    16'h3131: p = 16'h313A;
                    16'h3141: p = 16'h313B;
                    16'h3142: p = 16'h313C;
                    16'h3145: p = 16'h313D;
                    16'h314C: p = 16'h313E;
                    16'h314D: p = 16'h313F;
                    16'h314E: p = 16'h3140;
                    default:  p = 16'h0000;
                endcase
            end
            16'h3142: if (b == 16'h3145) p = 16'h3144;
            16'h3157: begin
                if (b == 16'h314F) p = 16'h3158;
                else if (b == 16'h3150) p = 16'h3159;
                else if (b == 16'h3163) p = 16'h315A;
            end
            16'h315C: begin
                if (b == 16'h3153) p = 16'h315D;
                else if (b == 16'h3154) p = 16'h315E;
                else if (b == 16'h3163) p = 16'h315F;
            end
            16'h3161: if (b == 16'h3163) p = 16'h3162;
            default: p = 16'h0000;
        endcase
        return p;
    endfunction

    function automatic bit joinable(input logic [15:0] a, input logic [15:0] b);
        return a == 16'h0000 || b == 16'h0000 || pair_code(a, b) != 16'h0000;
    endfunction

    function automatic logic [15:0] merge_jamo(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] p;
        p = pair_code(a, b);
        if (a == 16'h0000) return b;
        if (b == 16'h0000) return a;
        return (p != 16'h0000) ? p : a;
    endfunction

    // position in the syllable table, -1 where the consonant has no place
    function automatic int table_slot(input logic [15:0] c, input logic [29:0] holes);
        int idx;
        int n;
        if (c < hjc_pkg::CONS_FIRST || c > hjc_pkg::CONS_LAST) return -1;
        idx = int'(c - hjc_pkg::CONS_FIRST);
        if (holes[idx]) return -1;
        n = 0;
        for (int i = 0; i < idx; i++) if (holes[i]) n++;
        return idx - n;
    endfunction

    function automatic hjc_pkg::result_t syllable(input hjc_pkg::jstate_t s);
        logic [15:0]      ini;
        logic [15:0]      med;
        logic [15:0]      fin;
        int               is;
        int               fs;
        hjc_pkg::result_t r;
        r   = '0;
        ini = jamo_code(s.ini);
        med = merge_jamo(jamo_code(s.m0), jamo_code(s.m1));
        fin = merge_jamo(jamo_code(s.f0), jamo_code(s.f1));
        is  = table_slot(ini, INI_HOLES);
        fs  = 0;
        if (fin != 16'h0000) begin
            fs = table_slot(fin, FIN_HOLES);
            if (fs >= 0) fs = fs + 1;
        end
        if (ini == 16'h0000) begin
            r.code = med;
        end else if (med == 16'h0000) begin
            r.code = ini;
        end else if (is < 0 || fs < 0 || med < VOW_FIRST || med > hjc_pkg::VOW_LAST) begin
            r.code = hjc_pkg::BAD_CODE;
            r.bad  = 1'b1;
        end else begin
            r.code = 16'(int'(hjc_pkg::SYL_BASE) + 588 * is + 28 * int'(med - VOW_FIRST)
                         + fs);
        end
        return r;
    endfunction

    task automatic emit_char(input logic [15:0] code, input logic prog, input logic bad);
        hjc_pkg::result_t r;
        if (code == 16'h0000 || key_results.size() >= 2) return;
        r.code = code;
        r.prog = prog;
        r.bad  = bad;
        r.last = 1'b0;
        key_results.push_back(r);
    endtask

    task automatic flush_syllable();
        hjc_pkg::result_t r;
        r    = syllable(comp);
        comp = '0;
        emit_char(r.code, 1'b0, r.bad);
    endtask

    task automatic predict_key(input logic [15:0] key);
        hjc_pkg::jamo_t   moved;
        logic             no_final;
        hjc_pkg::result_t r;
        key_results.delete();
        if (key == hjc_pkg::KEY_BS) begin
            if (comp.f1 != '0) comp.f1 = '0;
            else if (comp.f0 != '0) comp.f0 = '0;
            else if (comp.m1 != '0) comp.m1 = '0;
            else if (comp.m0 != '0) comp.m0 = '0;
            else if (comp.ini != '0) comp.ini = '0;
            else emit_char(key, 1'b0, 1'b0);
        end else if (key < hjc_pkg::CONS_FIRST || key > hjc_pkg::VOW_LAST) begin
            flush_syllable();
            emit_char(key, 1'b0, 1'b0);
        end else begin
            if (key <= hjc_pkg::CONS_LAST) begin
                no_final = key == KEY_SSANG_D || key == KEY_SSANG_B || key == KEY_SSANG_J;
                if (comp.ini == '0 || comp.m0 == '0 || no_final || comp.f1 != '0 ||
                    !joinable(jamo_code(comp.f0), key)) begin
                    flush_syllable();
                    comp.ini = jamo_slot(key);
                end else if (comp.f0 == '0) begin
                    comp.f0 = jamo_slot(key);
                end else begin
                    comp.f1 = jamo_slot(key);
                end
            end else begin
                if (comp.f0 != '0) begin
                    // newest final moves over to open the next syllable
                    if (comp.f1 == '0) begin
                        moved   = comp.f0;
                        comp.f0 = '0;
                    end else begin
                        moved   = comp.f1;
                        comp.f1 = '0;
                    end
                    flush_syllable();
                    comp.ini = moved;
                    comp.m0  = jamo_slot(key);
                end else if (comp.m1 != '0 || !joinable(jamo_code(comp.m0), key)) begin
                    flush_syllable();
                    comp.m0 = jamo_slot(key);
                end else if (comp.m0 == '0) begin
                    comp.m0 = jamo_slot(key);
                end else begin
                    comp.m1 = jamo_slot(key);
                end
            end
            r = syllable(comp);
            emit_char(r.code, 1'b1, r.bad);
        end
        if (key_results.size() != 0) key_results[key_results.size() - 1].last = 1'b1;
        if (key_results.size() == 2) double_keys++;
        foreach (key_results[i]) expected_chars.push_back(key_results[i]);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic logic [15:0] random_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 44) begin
            if ($urandom_range(1) == 0) return hjc_pkg::CONS_FIRST + 16'($urandom_range(29));
            case ($urandom_range(9))
                0: return 16'h3131;
                1: return 16'h3134;
                2: return 16'h3139;
                3: return 16'h3142;
                4: return 16'h3145;
                5: return 16'h3148;
                6: return 16'h314E;
                7: return 16'h3141;
                8: return 16'h314C;
                default: return 16'h314D;
            endcase
        end else if (sel < 80) begin
            if ($urandom_range(1) == 0) return VOW_FIRST + 16'($urandom_range(20));
            case ($urandom_range(7))
                0: return 16'h3157;
                1: return 16'h315C;
                2: return 16'h3161;
                3: return 16'h314F;
                4: return 16'h3150;
                5: return 16'h3153;
                6: return 16'h3154;
                default: return 16'h3163;
            endcase
        end else if (sel < 90) begin
            return hjc_pkg::KEY_BS;
        end else if (sel < 91) begin
            return 16'h0000;
        end else if (sel < 98) begin
            return 16'($urandom);
        end
        return ($urandom_range(1) == 0) ? hjc_pkg::JAMO_BASE : hjc_pkg::VOW_LAST + 16'h0001;
    endfunction

    task automatic queue_random(input int n);
        repeat (n) pending_keys.push_back(random_key());
    endtask

    task automatic drain_keys();
        while (pending_keys.size() != 0 || s_tvalid) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // driver, receiver, monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_key(s_tdata);
                keys_accepted <= keys_accepted + 1;
            end
            if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_keys.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // one long back-pressure stretch so the input side fills and stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && keys_accepted >= 150) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_char.code = m_tdata;
            got_char.prog = m_tuser[0];
            got_char.bad  = m_tuser[1];
            got_char.last = m_tlast;
            chars_seen++;
            if (got_char.bad) bad_chars_seen++;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h prog %b bad %b last %b",
                         $time, got_char.code, got_char.prog, got_char.bad, got_char.last);
                mismatches++;
            end else begin
                exp_char = expected_chars.pop_front();
                check_field("out_code", exp_char.code, got_char.code);
                check_field("in_progress", 16'(exp_char.prog), 16'(got_char.prog));
                check_field("bad_initial", 16'(exp_char.bad), 16'(got_char.bad));
                check_field("last_of_run", 16'(exp_char.last), 16'(got_char.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        comp = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        send_idle_pct <= 38;
        recv_idle_pct <= 60;
        // backspace on empty buffer, key 0, compound final then final moving over,
        // backspace chain, compound initial, compound vowels, no-final consonants
        pending_keys = '{16'h0008, 16'h0000, 16'h3131, 16'h314F, 16'h3139, 16'h3131,
                         16'h314F, 16'h0008, 16'h0008, 16'h3133, 16'h314F, 16'h3157,
                         16'h314F, 16'h3163, 16'h3138, 16'h3163, 16'h3138, 16'h314E,
                         16'h3158, 16'h3142, 16'h3145, 16'h0041, 16'hFFFF, 16'h3130,
                         16'h3164};
        queue_random(RANDOM_PER_PHASE);
        drain_keys();

        send_idle_pct <= 60;
        recv_idle_pct <= 38;
        queue_random(RANDOM_PER_PHASE);
        drain_keys();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        queue_random(RANDOM_PER_PHASE);
        drain_keys();

        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered %0d keys, %0d characters out, %0d with bad initial, %0d keys with two.",
                 keys_accepted, chars_seen, bad_chars_seen, double_keys);
        $display("Long receiver stall applied: %0d, mismatches: %0d", hold_done, mismatches);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("** hangul_jamo_composer_top: PASSED **");
        end else begin
            $display("** hangul_jamo_composer_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("Timeout with %0d characters outstanding", expected_chars.size());
        $display("** hangul_jamo_composer_top: FAILED **");
        $finish;
    end

endmodule
